### rtl/core/two_sided_bump_allocator_assert.svh
// Assertion macros for the two-sided bump allocator.
`ifndef TWO_SIDED_BUMP_ALLOCATOR_ASSERT_SVH
`define TWO_SIDED_BUMP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define TSBA_ASSERT_SAME(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
`define TSBA_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define TSBA_ASSERT_SAME(label, clk, rst, cond, prop)
`define TSBA_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

### rtl/core/tsba_pkg.sv
// Shared types and constants for the two-sided bump allocator.
package tsba_pkg;

  localparam int ADDR_BITS_DEFAULT = 32;
  localparam int DATA_W = 32;
  localparam int CFG_INDEX_W = 2;

  localparam logic [7:0] ALIGN_16_M1  = 8'h0f;
  localparam logic [7:0] ALIGN_64_M1  = 8'h3f;
  localparam logic [7:0] ALIGN_256_M1 = 8'hff;

  typedef enum logic {
    ACT_ALLOC  = 1'b0,
    ACT_REINIT = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ALIGN_16  = 2'd0,
    ALIGN_64  = 2'd1,
    ALIGN_256 = 2'd2
  } align_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_OOM    = 2'd1,
    ST_ZERO   = 2'd2,
    ST_REINIT = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GLOBAL_BASE = 2'd0,
    REG_GLOBAL_SIZE = 2'd1,
    REG_DEBUG_BASE  = 2'd2,
    REG_DEBUG_SIZE  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    action_t           action;
    logic              heap_select;
    logic              from_top;
    logic [1:0]        alignment;
    logic [DATA_W-1:0] request_size;
    logic              zero_fill;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] address;
    status_t           status;
    logic              clear_request;
    logic [DATA_W-1:0] bottom_used;
  } res_t;

endpackage

### rtl/core/tsba_cfg.sv
// Heap configuration registers and the pointer values they load at reinit.
module tsba_cfg #(
  parameter int ADDR_BITS = tsba_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tsba_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tsba_pkg::DATA_W-1:0]         cfg_data,
  output logic [1:0][ADDR_BITS-1:0]           load_base,
  output logic [1:0][ADDR_BITS-1:0]           load_top
);

  logic [1:0][tsba_pkg::DATA_W-1:0] base;
  logic [1:0][tsba_pkg::DATA_W-1:0] size;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
      size <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tsba_pkg::REG_GLOBAL_BASE: base[0] <= cfg_data;
        tsba_pkg::REG_GLOBAL_SIZE: size[0] <= cfg_data;
        tsba_pkg::REG_DEBUG_BASE:  base[1] <= cfg_data;
        tsba_pkg::REG_DEBUG_SIZE:  size[1] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The top end saturates at the highest address when base plus size wraps.
  always_comb begin
    logic [ADDR_BITS:0] sum;
    for (int h = 0; h < 2; h++) begin
      load_base[h] = ADDR_BITS'(base[h]);
      sum = {1'b0, ADDR_BITS'(base[h])} + {1'b0, ADDR_BITS'(size[h])};
      load_top[h] = sum[ADDR_BITS] ? '1 : sum[ADDR_BITS-1:0];
    end
  end

endmodule

### rtl/core/tsba_alloc.sv
// Single-pass allocation datapath for one heap: alignment, bounds and result.
module tsba_alloc #(
  parameter int ADDR_BITS = tsba_pkg::ADDR_BITS_DEFAULT
) (
  input  tsba_pkg::req_t        req,
  input  logic [ADDR_BITS-1:0]  lo_ptr,
  input  logic [ADDR_BITS-1:0]  hi_ptr,
  input  logic [ADDR_BITS-1:0]  lo_base,
  output tsba_pkg::res_t        res,
  output logic                  bot_wr,
  output logic                  top_wr,
  output logic [ADDR_BITS-1:0]  new_ptr
);

  localparam int CW = ((ADDR_BITS > tsba_pkg::DATA_W) ? ADDR_BITS : tsba_pkg::DATA_W) + 1;

  logic [ADDR_BITS-1:0] am1;
  logic [ADDR_BITS-1:0] mask;
  logic [ADDR_BITS:0]   bsum;
  logic                 bwrap;
  logic [ADDR_BITS-1:0] bstart;
  logic [CW-1:0]        size_c;
  logic [CW-1:0]        bend;
  logic [CW-1:0]        tdiff;
  logic [ADDR_BITS-1:0] tstart;
  logic [ADDR_BITS-1:0] addr;
  logic [ADDR_BITS-1:0] bot_after;

  always_comb begin
    case (req.alignment)
      tsba_pkg::ALIGN_64:  am1 = ADDR_BITS'(tsba_pkg::ALIGN_64_M1);
      tsba_pkg::ALIGN_256: am1 = ADDR_BITS'(tsba_pkg::ALIGN_256_M1);
      default:             am1 = ADDR_BITS'(tsba_pkg::ALIGN_16_M1);
    endcase
  end

  assign mask   = ~am1;
  assign bsum   = {1'b0, lo_ptr} + {1'b0, am1};
  assign bwrap  = bsum[ADDR_BITS];
  assign bstart = bsum[ADDR_BITS-1:0] & mask;
  assign size_c = CW'(req.request_size);
  assign bend   = CW'(bstart) + size_c;
  assign tdiff  = CW'(hi_ptr) - size_c;
  assign tstart = ADDR_BITS'(tdiff) & mask;

  always_comb begin
    res.status        = tsba_pkg::ST_OK;
    res.clear_request = 1'b0;
    bot_wr            = 1'b0;
    top_wr            = 1'b0;
    new_ptr           = bend[ADDR_BITS-1:0];
    addr              = '0;
    if (req.action == tsba_pkg::ACT_REINIT) begin
      res.status = tsba_pkg::ST_REINIT;
    end else if (!req.from_top) begin
      if (size_c == '0) begin
        addr       = bstart;
        res.status = tsba_pkg::ST_ZERO;
      end else if (bwrap || size_c > CW'(~bstart) || CW'(hi_ptr) < bend) begin
        res.status = tsba_pkg::ST_OOM;
      end else begin
        bot_wr            = 1'b1;
        addr              = bstart;
        res.clear_request = req.zero_fill;
      end
    end else begin
      new_ptr = tstart;
      if (size_c == '0) begin
        addr       = hi_ptr & mask;
        res.status = tsba_pkg::ST_ZERO;
      end else if (size_c > CW'(hi_ptr) || lo_ptr >= tstart) begin
        res.status = tsba_pkg::ST_OOM;
      end else begin
        top_wr            = 1'b1;
        addr              = tstart;
        res.clear_request = req.zero_fill;
      end
    end
    // After a reinit the bottom pointer equals its base, so usage reads zero.
    bot_after   = bot_wr ? new_ptr : lo_ptr;
    res.address = tsba_pkg::DATA_W'(addr);
    res.bottom_used = (req.action == tsba_pkg::ACT_REINIT) ? '0 :
                      tsba_pkg::DATA_W'(bot_after - lo_base);
  end

endmodule

### rtl/core/two_sided_bump_allocator.sv
// Top level of the two-sided bump allocator: beat registers and heap pointers.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  action heap_select from_top alignment
//                                           request_size zero_fill
//  out      output     out_valid/out_stall  address status clear_request bottom_used
//  cfg      input      cfg_valid/cfg_ready  cfg_index cfg_data
//
// One beat per cycle while out_stall is low; a beat sits in the input register while
// align, add and compare act on it; result and pointer write back share an edge.
// Reset clears the configuration registers and all heap pointers to zero.
// A stalled result holds the input register, which then stalls the input side.
`include "two_sided_bump_allocator_assert.svh"
module two_sided_bump_allocator #(
  parameter int ADDR_BITS = tsba_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             action,
  input  logic                             heap_select,
  input  logic                             from_top,
  input  logic [1:0]                       alignment,
  input  logic [tsba_pkg::DATA_W-1:0]      request_size,
  input  logic                             zero_fill,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tsba_pkg::DATA_W-1:0]      address,
  output logic [1:0]                       status,
  output logic                             clear_request,
  output logic [tsba_pkg::DATA_W-1:0]      bottom_used,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tsba_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tsba_pkg::DATA_W-1:0]      cfg_data
);

  logic                        in_full;
  tsba_pkg::req_t              in_req;
  tsba_pkg::res_t              out_res;
  tsba_pkg::res_t              res;
  logic                        advance;
  logic                        accept;
  logic                        bot_wr;
  logic                        top_wr;
  logic [ADDR_BITS-1:0]        new_ptr;
  logic [1:0][ADDR_BITS-1:0]   load_base;
  logic [1:0][ADDR_BITS-1:0]   load_top;
  logic [1:0][ADDR_BITS-1:0]   bottom_free;
  logic [1:0][ADDR_BITS-1:0]   top_ptr;
  logic [1:0][ADDR_BITS-1:0]   bottom_base;

  tsba_cfg #(.ADDR_BITS(ADDR_BITS)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .load_base (load_base),
    .load_top  (load_top)
  );

  tsba_alloc #(.ADDR_BITS(ADDR_BITS)) u_alloc (
    .req      (in_req),
    .lo_ptr   (bottom_free[in_req.heap_select]),
    .hi_ptr   (top_ptr[in_req.heap_select]),
    .lo_base  (bottom_base[in_req.heap_select]),
    .res      (res),
    .bot_wr   (bot_wr),
    .top_wr   (top_wr),
    .new_ptr  (new_ptr)
  );

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_req.action       <= tsba_pkg::action_t'(action);
      in_req.heap_select  <= heap_select;
      in_req.from_top     <= from_top;
      in_req.alignment    <= alignment;
      in_req.request_size <= request_size;
      in_req.zero_fill    <= zero_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bottom_free <= '0;
      top_ptr     <= '0;
      bottom_base <= '0;
    end else if (advance) begin
      if (in_req.action == tsba_pkg::ACT_REINIT) begin
        bottom_free <= load_base;
        bottom_base <= load_base;
        top_ptr     <= load_top;
      end else if (bot_wr) begin
        bottom_free[in_req.heap_select] <= new_ptr;
      end else if (top_wr) begin
        top_ptr[in_req.heap_select] <= new_ptr;
      end
    end
  end

  assign address       = out_res.address;
  assign status        = out_res.status;
  assign clear_request = out_res.clear_request;
  assign bottom_used   = out_res.bottom_used;

  `TSBA_ASSERT_SAME(a_oom_no_addr, clk, rst,
                    out_valid && status == tsba_pkg::ST_OOM,
                    address == '0 && clear_request == 1'b0)
  `TSBA_ASSERT_NEXT(a_reinit_result, clk, rst,
                    advance && in_req.action == tsba_pkg::ACT_REINIT,
                    out_valid && status == tsba_pkg::ST_REINIT && bottom_used == '0)
  `TSBA_ASSERT_NEXT(a_held_item, clk, rst, in_full && !advance,
                    in_full && $stable(in_req))

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the two-sided bump allocator.

class alloc_tracker;
  logic [31:0] heap_reg [4];
  logic [31:0] lo_base [2];
  logic [31:0] lo_ptr [2];
  logic [31:0] hi_ptr [2];
  tsba_pkg::res_t pending_grants [$];
  int failures;

  function new();
    foreach (heap_reg[i]) heap_reg[i] = '0;
    load_heap(0, '0, '0);
    load_heap(1, '0, '0);
    failures = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] data);
    heap_reg[idx] = data;
  endfunction

  // The top pointer saturates when base plus size runs past the address space.
  function void load_heap(int h, logic [31:0] base, logic [31:0] span);
    logic [32:0] limit;
    limit = {1'b0, base} + span;
    lo_base[h] = base;
    lo_ptr[h] = base;
    hi_ptr[h] = limit[32] ? '1 : limit[31:0];
  endfunction

  function void note_request(tsba_pkg::req_t r);
    int h;
    logic [31:0] mask_lo;
    logic [31:0] start;
    logic [32:0] rounded;
    logic [32:0] span_end;
    tsba_pkg::res_t g;
    h = int'(r.heap_select);
    case (r.alignment)
      tsba_pkg::ALIGN_64: mask_lo = 32'h3f;
      tsba_pkg::ALIGN_256: mask_lo = 32'hff;
      default: mask_lo = 32'hf;
    endcase
    g.address = '0;
    g.status = tsba_pkg::ST_OK;
    g.clear_request = 1'b0;
    if (r.action == tsba_pkg::ACT_REINIT) begin
      load_heap(0, heap_reg[tsba_pkg::REG_GLOBAL_BASE], heap_reg[tsba_pkg::REG_GLOBAL_SIZE]);
      load_heap(1, heap_reg[tsba_pkg::REG_DEBUG_BASE], heap_reg[tsba_pkg::REG_DEBUG_SIZE]);
      g.status = tsba_pkg::ST_REINIT;
    end else if (!r.from_top) begin
      rounded = {1'b0, lo_ptr[h]} + mask_lo;
      start = rounded[31:0] & ~mask_lo;
      span_end = {1'b0, start} + r.request_size;
      if (r.request_size == 0) begin
        g.address = start;
        g.status = tsba_pkg::ST_ZERO;
      end else if (rounded[32] || span_end[32] || {1'b0, hi_ptr[h]} < span_end) begin
        g.status = tsba_pkg::ST_OOM;
      end else begin
        lo_ptr[h] = span_end[31:0];
        g.address = start;
        g.clear_request = r.zero_fill;
      end
    end else begin
      start = (hi_ptr[h] - r.request_size) & ~mask_lo;
      if (r.request_size == 0) begin
        g.address = hi_ptr[h] & ~mask_lo;
        g.status = tsba_pkg::ST_ZERO;
      end else if (r.request_size > hi_ptr[h] || lo_ptr[h] >= start) begin
        g.status = tsba_pkg::ST_OOM;
      end else begin
        hi_ptr[h] = start;
        g.address = start;
        g.clear_request = r.zero_fill;
      end
    end
    g.bottom_used = lo_ptr[h] - lo_base[h];
    pending_grants.push_back(g);
  endfunction

  function void check_grant(tsba_pkg::res_t got);
    tsba_pkg::res_t want;
    if (pending_grants.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected result beat: address %h status %0d clear %0b bottom_used %h",
                 got.address, got.status, got.clear_request, got.bottom_used);
      return;
    end
    want = pending_grants.pop_front();
    if (got.address !== want.address || got.status !== want.status ||
        got.clear_request !== want.clear_request || got.bottom_used !== want.bottom_used) begin
      failures++;
      if (failures <= 10)
        $display("mismatch exp/act: addr %h/%h status %0d/%0d clr %0b/%0b used %h/%h",
                 want.address, got.address, want.status, got.status,
                 want.clear_request, got.clear_request, want.bottom_used, got.bottom_used);
    end
  endfunction

  function int pending();
    return pending_grants.size();
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 48;

  localparam logic HEAP_GLOBAL = 1'b0;
  localparam logic HEAP_DEBUG  = 1'b1;
  localparam logic SIDE_BOTTOM = 1'b0;
  localparam logic SIDE_TOP    = 1'b1;
  localparam logic [1:0] ALIGN_CODE_16    = tsba_pkg::ALIGN_16;
  localparam logic [1:0] ALIGN_CODE_64    = tsba_pkg::ALIGN_64;
  localparam logic [1:0] ALIGN_CODE_256   = tsba_pkg::ALIGN_256;
  localparam logic [1:0] ALIGN_CODE_SPARE = 2'd3;
  localparam tsba_pkg::action_t DO_ALLOC  = tsba_pkg::ACT_ALLOC;
  localparam tsba_pkg::action_t DO_REINIT = tsba_pkg::ACT_REINIT;

  localparam int STALL_NONE     = 0;
  localparam int STALL_LIGHT    = 1;
  localparam int STALL_HEAVY    = 2;
  localparam int STALL_PERIODIC = 3;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic action;
  logic heap_select;
  logic from_top;
  logic [1:0] alignment;
  logic [tsba_pkg::DATA_W-1:0] request_size;
  logic zero_fill;
  logic out_valid;
  logic out_stall;
  logic [tsba_pkg::DATA_W-1:0] address;
  logic [1:0] status;
  logic clear_request;
  logic [tsba_pkg::DATA_W-1:0] bottom_used;
  logic cfg_valid;
  logic cfg_ready;
  logic [tsba_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [tsba_pkg::DATA_W-1:0] cfg_data;

  alloc_tracker tracker = new();
  tsba_pkg::req_t seen_req;
  tsba_pkg::res_t seen_res;
  int stall_mode;
  int unsigned stall_phase = 0;
  int cycle_count = 0;
  bit idle_gaps;
  int burst_left;
  logic [31:0] heap_size [2];

  two_sided_bump_allocator uut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver backpressure, shaped per phase.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= (stall_phase % 7) < 3;
    endcase
  end

  // Requests are noted before results are checked, so the order of the two
  // handshakes within one edge cannot matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        seen_req.action = tsba_pkg::action_t'(action);
        seen_req.heap_select = heap_select;
        seen_req.from_top = from_top;
        seen_req.alignment = alignment;
        seen_req.request_size = request_size;
        seen_req.zero_fill = zero_fill;
        tracker.note_request(seen_req);
      end
      if (out_valid && !out_stall) begin
        seen_res.address = address;
        seen_res.status = tsba_pkg::status_t'(status);
        seen_res.clear_request = clear_request;
        seen_res.bottom_used = bottom_used;
        tracker.check_grant(seen_res);
      end
    end
  end

  function automatic tsba_pkg::req_t alloc_item(tsba_pkg::action_t act, logic heap,
                                                logic side, logic [1:0] al,
                                                logic [31:0] size, logic zf);
    tsba_pkg::req_t r;
    r.action = act;
    r.heap_select = heap;
    r.from_top = side;
    r.alignment = al;
    r.request_size = size;
    r.zero_fill = zf;
    return r;
  endfunction

  function automatic tsba_pkg::req_t rand_request();
    tsba_pkg::req_t r;
    int pick;
    logic [31:0] size;
    r.action = ($urandom_range(0, 99) < 5) ? DO_REINIT : DO_ALLOC;
    r.heap_select = 1'($urandom_range(0, 1));
    r.from_top = 1'($urandom_range(0, 1));
    r.alignment = 2'($urandom_range(0, 3));
    r.zero_fill = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 8) size = '0;
    else if (pick < 55) size = $urandom_range(1, 'h300);
    else if (pick < 70) size = $urandom_range('h301, 'h10000);
    else if (pick < 85) size = $urandom;
    else if (pick < 93)
      size = (heap_size[r.heap_select] >> $urandom_range(0, 3)) + $urandom_range(0, 2) - 1;
    else size = 32'hffffffff - $urandom_range(0, 'h1ff);
    r.request_size = size;
    return r;
  endfunction

  task automatic push_request(input tsba_pkg::req_t r);
    in_valid <= 1'b1;
    action <= r.action;
    heap_select <= r.heap_select;
    from_top <= r.from_top;
    alignment <= r.alignment;
    request_size <= r.request_size;
    zero_fill <= r.zero_fill;
    do @(posedge clk); while (in_stall);
    if (idle_gaps) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  // Returns once every expected result has arrived and the pipeline has emptied.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_beat(input tsba_pkg::cfg_reg_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_heaps(input logic [31:0] gb, gs, db, ds);
    cfg_beat(tsba_pkg::REG_GLOBAL_BASE, gb);
    cfg_beat(tsba_pkg::REG_GLOBAL_SIZE, gs);
    cfg_beat(tsba_pkg::REG_DEBUG_BASE, db);
    cfg_beat(tsba_pkg::REG_DEBUG_SIZE, ds);
    cfg_valid <= 1'b0;
    heap_size[0] = gs;
    heap_size[1] = ds;
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    action <= DO_ALLOC;
    heap_select <= HEAP_GLOBAL;
    from_top <= SIDE_BOTTOM;
    alignment <= ALIGN_CODE_16;
    request_size <= '0;
    zero_fill <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= tsba_pkg::REG_GLOBAL_BASE;
    cfg_data <= '0;
    stall_mode <= STALL_NONE;
    heap_size[0] = '0;
    heap_size[1] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    stall_mode <= STALL_LIGHT;
    idle_gaps = 1'b1;
    burst_left = $urandom_range(1, 12);

    // Both heaps are empty straight out of reset.
    push_request(alloc_item(DO_ALLOC, HEAP_GLOBAL, SIDE_BOTTOM, ALIGN_CODE_16, 32'h0, 1'b0));
    push_request(alloc_item(DO_ALLOC, HEAP_DEBUG, SIDE_BOTTOM, ALIGN_CODE_256, 32'h1, 1'b1));
    push_request(alloc_item(DO_ALLOC, HEAP_GLOBAL, SIDE_TOP, ALIGN_CODE_64, 32'hffffffff, 1'b1));
    quiesce();

    // The debug heap sits at the very top of the address space and saturates.
    program_heaps(32'h10000003, 32'h00002000, 32'hffffff01, 32'hffffffff);
    push_request(alloc_item(DO_REINIT, HEAP_GLOBAL, SIDE_BOTTOM, ALIGN_CODE_16, 32'h0, 1'b0));
    push_request(alloc_item(DO_ALLOC, HEAP_GLOBAL, SIDE_BOTTOM, ALIGN_CODE_256, 32'h10, 1'b1));
    push_request(alloc_item(DO_ALLOC, HEAP_GLOBAL, SIDE_BOTTOM, ALIGN_CODE_SPARE, 32'h1, 1'b0));
    push_request(alloc_item(DO_ALLOC, HEAP_GLOBAL, SIDE_TOP, ALIGN_CODE_64, 32'h40, 1'b1));
    push_request(alloc_item(DO_ALLOC, HEAP_GLOBAL, SIDE_TOP, ALIGN_CODE_256, 32'h0, 1'b1));
    push_request(alloc_item(DO_ALLOC, HEAP_GLOBAL, SIDE_BOTTOM, ALIGN_CODE_64, 32'h0, 1'b1));
    push_request(alloc_item(DO_ALLOC, HEAP_GLOBAL, SIDE_BOTTOM, ALIGN_CODE_16, 32'hffffffff,
                            1'b0));
    push_request(alloc_item(DO_ALLOC, HEAP_GLOBAL, SIDE_TOP, ALIGN_CODE_16, 32'h80000000, 1'b1));
    push_request(alloc_item(DO_ALLOC, HEAP_GLOBAL, SIDE_BOTTOM, ALIGN_CODE_16, 32'h3000, 1'b1));
    push_request(alloc_item(DO_ALLOC, HEAP_DEBUG, SIDE_BOTTOM, ALIGN_CODE_256, 32'h1, 1'b1));
    push_request(alloc_item(DO_ALLOC, HEAP_DEBUG, SIDE_BOTTOM, ALIGN_CODE_256, 32'h0, 1'b0));
    push_request(alloc_item(DO_ALLOC, HEAP_DEBUG, SIDE_BOTTOM, ALIGN_CODE_16, 32'h10, 1'b1));
    push_request(alloc_item(DO_ALLOC, HEAP_DEBUG, SIDE_TOP, ALIGN_CODE_16, 32'h20, 1'b0));
    push_request(alloc_item(DO_ALLOC, HEAP_DEBUG, SIDE_TOP, ALIGN_CODE_16, 32'hc0, 1'b1));
    push_request(alloc_item(DO_ALLOC, HEAP_DEBUG, SIDE_TOP, ALIGN_CODE_256, 32'hffffffff, 1'b0));
    // Exactly fills the gap between the two global pointers, then the top side
    // finds no room left.
    push_request(alloc_item(DO_ALLOC, HEAP_GLOBAL, SIDE_BOTTOM, ALIGN_CODE_16, 32'h1ea0, 1'b1));
    push_request(alloc_item(DO_ALLOC, HEAP_GLOBAL, SIDE_TOP, ALIGN_CODE_16, 32'h10, 1'b1));
    push_request(alloc_item(DO_REINIT, HEAP_DEBUG, SIDE_TOP, ALIGN_CODE_256, 32'hffffffff, 1'b1));
    quiesce();

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase == 0)
        program_heaps(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h0);
      else if (phase == 1)
        program_heaps(32'h0, 32'h0, 32'h0, 32'hffffffff);
      else
        program_heaps($urandom,
                      ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range('h200, 'h4000),
                      $urandom,
                      ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range('h200, 'h4000));
      stall_mode <= phase % 4;
      idle_gaps = (phase % 4) != 0;
      push_request(alloc_item(DO_REINIT, HEAP_GLOBAL, SIDE_BOTTOM, ALIGN_CODE_16, 32'h0, 1'b0));
      for (int n = 0; n < PHASE_ITEMS; n++) push_request(rand_request());
      quiesce();
    end

    repeat (8) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/tsba_pkg.sv
rtl/core/tsba_cfg.sv
rtl/core/tsba_alloc.sv
rtl/core/two_sided_bump_allocator.sv
tb/sv/tb.sv
